### sv/gca_pkg.sv
// ----------------------------------------------------------------------------
// gca_pkg: shared types and constants of the glyph cache atlas allocator
// holds geometry of the cache, status codes, register indexes and the
// controller state type
// ----------------------------------------------------------------------------
package gca_pkg;

	localparam int BUCKETS      = 256;
	localparam int BUCKET_DEPTH = 8;
	localparam int MAX_TEXTURES = 16;

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int POS_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int SLOTS  = BUCKETS * BUCKET_DEPTH;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int TC_W   = 5;

	localparam logic [10:0] PEN_MAX   = 11'd2047;
	localparam logic [8:0]  ROW_MAX   = 9'd511;
	localparam logic [9:0]  COORD_MAX = 10'd1023;

	// status codes
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_INSERT   = 3'd1;
	localparam logic [2:0] ST_NEW_TEX  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EXHAUST  = 3'd4;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PAD    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_PLACE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture input item
		logic rd;         // read slot at pos
		logic pos_inc;    // advance walk position
		logic place;      // compute placement
		logic shift_rd;   // read slot k-1
		logic shift_wr;   // write slot k, decrement k
		logic ins_wr;     // write new entry, commit state
		logic res_hit;    // result from read record
		logic res_fail;   // result is failure
		logic res_ins;    // result is insertion
		logic out_set;    // present result
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic walk_done;  // pos reached fill
		logic hit;        // key equals code
		logic stop;       // key greater than code
		logic full;       // bucket full
		logic exhaust;    // no texture left
		logic shift_done; // k reached pos
		logic out_busy;   // result register occupied
	} stat_t;

	typedef struct packed {
		logic [7:0]  adv;
		logic [7:0]  by;
		logic [7:0]  bx;
		logic [7:0]  h;
		logic [7:0]  w;
		logic [9:0]  y;
		logic [9:0]  x;
		logic [3:0]  tex;
	} rec_t;

endpackage

### sv/gca_ctrl.sv
// ----------------------------------------------------------------------------
// gca_ctrl: controller of the glyph cache atlas allocator
// sequences bucket walk, placement, insertion shift and result handoff
// ----------------------------------------------------------------------------
module gca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gca_pkg::stat_t st,
	output gca_pkg::cmd_t  cmd
);

	gca_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gca_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gca_pkg::S_IDLE: if (in_valid) state_d = gca_pkg::S_READ;
			gca_pkg::S_READ: begin
				if (st.walk_done) state_d = gca_pkg::S_PLACE;
				else state_d = gca_pkg::S_CMP;
			end
			gca_pkg::S_CMP: begin
				priority if (st.hit) state_d = gca_pkg::S_OUT;
				else if (st.stop) state_d = gca_pkg::S_PLACE;
				else state_d = gca_pkg::S_READ;
			end
			gca_pkg::S_PLACE: begin
				priority if (st.full || st.exhaust) state_d = gca_pkg::S_OUT;
				else if (st.shift_done) state_d = gca_pkg::S_WRITE;
				else state_d = gca_pkg::S_SHIFT_RD;
			end
			gca_pkg::S_SHIFT_RD: state_d = gca_pkg::S_SHIFT_WR;
			gca_pkg::S_SHIFT_WR: begin
				if (st.shift_done) state_d = gca_pkg::S_WRITE;
				else state_d = gca_pkg::S_SHIFT_RD;
			end
			gca_pkg::S_WRITE: state_d = gca_pkg::S_OUT;
			gca_pkg::S_OUT: if (!st.out_busy) state_d = gca_pkg::S_IDLE;
			default: state_d = gca_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gca_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			gca_pkg::S_READ: cmd.rd = !st.walk_done;
			gca_pkg::S_CMP: begin
				cmd.pos_inc = !st.hit && !st.stop;
				cmd.res_hit = st.hit;
			end
			gca_pkg::S_PLACE: begin
				cmd.place = 1'b1;
				cmd.res_fail = st.full || st.exhaust;
			end
			gca_pkg::S_SHIFT_RD: cmd.shift_rd = 1'b1;
			gca_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
			gca_pkg::S_WRITE: begin
				cmd.ins_wr = 1'b1;
				cmd.res_ins = 1'b1;
			end
			gca_pkg::S_OUT: cmd.out_set = !st.out_busy;
			default: ;
		endcase
	end

endmodule

### sv/gca_dp.sv
// ----------------------------------------------------------------------------
// gca_dp: datapath of the glyph cache atlas allocator
// key and record memories, fill table, pen state, placement and result
// ----------------------------------------------------------------------------
module gca_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [63:0]    in_data,
	input  logic           cfg_valid,
	input  logic [1:0]     cfg_index,
	input  logic [10:0]    cfg_data,
	input  gca_pkg::cmd_t  cmd,
	output gca_pkg::stat_t st,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [71:0]    out_data
);

	localparam int BW = gca_pkg::BKT_W;
	localparam int PW = gca_pkg::POS_W;
	localparam int FW = gca_pkg::FILL_W;
	localparam int SW = gca_pkg::SLOT_W;

	// configuration
	logic [10:0] aw_q, ah_q;
	logic [3:0]  pad_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= 11'd128;
			ah_q <= 11'd128;
			pad_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gca_pkg::REG_WIDTH:  aw_q <= cfg_data;
				gca_pkg::REG_HEIGHT: ah_q <= cfg_data;
				gca_pkg::REG_PAD:    pad_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [20:0] code_q;
	logic [7:0]  w_q, h_q, bx_q, by_q, adv_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= in_data[20:0];
			w_q    <= in_data[28:21];
			h_q    <= in_data[36:29];
			bx_q   <= in_data[44:37];
			by_q   <= in_data[52:45];
			adv_q  <= in_data[60:53];
		end
	end
	logic [BW-1:0] bkt;
	assign bkt = code_q[BW-1:0];
	logic [BW-1:0] in_bkt;
	assign in_bkt = in_data[BW-1:0];

	// fill table with valid bits
	logic [FW-1:0] fill_mem [gca_pkg::BUCKETS];
	logic [gca_pkg::BUCKETS-1:0] fill_vld_q;
	logic [FW-1:0] n_q;

	// walk position and shift index
	logic [FW-1:0] pos_q, k_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fill_vld_q <= '0;
		else if (cmd.ins_wr) fill_vld_q[bkt] <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.ins_wr) fill_mem[bkt] <= FW'(n_q + 1'b1);
	end
	always_ff @(posedge clk) begin
		if (cmd.load) pos_q <= '0;
		else if (cmd.pos_inc) pos_q <= pos_q + 1'b1;
		// fill of the incoming bucket, read as the beat is taken
		if (cmd.load) n_q <= fill_vld_q[in_bkt] ? fill_mem[in_bkt] : '0;
		if (cmd.place) k_q <= n_q;
		else if (cmd.shift_wr) k_q <= k_q - 1'b1;
	end

	// key and record memories
	logic [20:0] key_mem [gca_pkg::SLOTS];
	logic [63:0] rec_mem [gca_pkg::SLOTS];
	logic [20:0] key_rd_q;
	logic [63:0] rec_rd_q;
	logic [SW-1:0] base;
	logic [SW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [20:0]   wr_key;
	logic [63:0]   wr_rec;
	logic [63:0]   new_rec;
	assign base = SW'(bkt) * SW'(gca_pkg::BUCKET_DEPTH);
	always_comb begin
		rd_addr = base + SW'(pos_q[PW-1:0]);
		if (cmd.shift_rd) rd_addr = base + SW'(PW'(k_q - 1'b1));
		wr_en = cmd.shift_wr || cmd.ins_wr;
		wr_addr = cmd.shift_wr ? base + SW'(k_q[PW-1:0]) : base + SW'(pos_q[PW-1:0]);
		wr_key = cmd.shift_wr ? key_rd_q : code_q;
		wr_rec = cmd.shift_wr ? rec_rd_q : new_rec;
	end
	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.shift_rd) begin
			key_rd_q <= key_mem[rd_addr];
			rec_rd_q <= rec_mem[rd_addr];
		end
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			rec_mem[wr_addr] <= wr_rec;
		end
	end

	// pen state
	logic [10:0] pen_x_q, pen_y_q;
	logic [8:0]  rh_q;
	logic [gca_pkg::TC_W-1:0] tc_q;
	logic [10:0] px_q, py_q;
	logic [8:0]  prh_q;
	logic [gca_pkg::TC_W-1:0] ptc_q;
	logic        newtex_q;

	// placement
	logic [11:0] wrap_sum, tex_sum;
	logic [11:0] py_wrap;
	logic        wrap, over;
	logic [10:0] px_a, py_a;
	logic [8:0]  rh_a;
	always_comb begin
		wrap_sum = 12'(pen_x_q) + 12'(pad_q) + 12'(w_q);
		wrap = wrap_sum > 12'(aw_q);
		py_wrap = 12'(pen_y_q) + 12'(rh_q);
		px_a = wrap ? 11'(pad_q) : pen_x_q;
		py_a = wrap ? ((py_wrap > 12'(gca_pkg::PEN_MAX)) ? gca_pkg::PEN_MAX : py_wrap[10:0])
			: pen_y_q;
		rh_a = wrap ? 9'(pad_q) : rh_q;
		tex_sum = 12'(py_a) + 12'(pad_q) + 12'(h_q);
		over = tex_sum > 12'(ah_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			newtex_q <= over;
			px_q  <= over ? 11'(pad_q) : px_a;
			py_q  <= over ? 11'(pad_q) : py_a;
			prh_q <= over ? 9'(pad_q) : rh_a;
			ptc_q <= over ? tc_q + 1'b1 : tc_q;
		end
	end

	assign new_rec = {adv_q, by_q, bx_q, h_q, w_q,
		(py_q > 11'(gca_pkg::COORD_MAX)) ? gca_pkg::COORD_MAX : py_q[9:0],
		(px_q > 11'(gca_pkg::COORD_MAX)) ? gca_pkg::COORD_MAX : px_q[9:0],
		4'(ptc_q - 1'b1)};

	// commit pen state
	logic [11:0] nx_sum;
	logic [9:0]  hp;
	logic [9:0]  rh_max;
	always_comb begin
		nx_sum = 12'(px_q) + 12'(w_q) + 12'(pad_q);
		hp = 10'(h_q) + 10'(pad_q);
		rh_max = (10'(prh_q) > hp) ? 10'(prh_q) : hp;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			rh_q <= '0;
			tc_q <= gca_pkg::TC_W'(1);
		end else if (cmd.ins_wr) begin
			pen_x_q <= (nx_sum > 12'(gca_pkg::PEN_MAX)) ? gca_pkg::PEN_MAX : nx_sum[10:0];
			pen_y_q <= py_q;
			rh_q <= (rh_max > 10'(gca_pkg::ROW_MAX)) ? gca_pkg::ROW_MAX : rh_max[8:0];
			tc_q <= ptc_q;
		end
	end

	// status
	always_comb begin
		st.walk_done  = pos_q >= n_q;
		st.hit        = key_rd_q == code_q;
		st.stop       = key_rd_q > code_q;
		st.full       = n_q >= FW'(gca_pkg::BUCKET_DEPTH);
		st.exhaust    = over && (tc_q >= gca_pkg::TC_W'(gca_pkg::MAX_TEXTURES));
		// shift ends once the entry in the insertion slot has moved up to the slot above it
		st.shift_done = cmd.place ? (n_q == pos_q) : (FW'(k_q - 1'b1) == pos_q);
		st.out_busy   = out_valid && !out_ready;
	end

	// pending result and output register
	logic [2:0]  res_st_q;
	logic [63:0] res_rec_q;
	always_ff @(posedge clk) begin
		priority if (cmd.res_hit) begin
			res_st_q <= gca_pkg::ST_HIT;
			res_rec_q <= rec_rd_q;
		end else if (cmd.res_fail) begin
			res_st_q <= st.full ? gca_pkg::ST_FULL : gca_pkg::ST_EXHAUST;
			res_rec_q <= '0;
		end else if (cmd.res_ins) begin
			res_st_q <= newtex_q ? gca_pkg::ST_NEW_TEX : gca_pkg::ST_INSERT;
			res_rec_q <= new_rec;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_set) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_set) out_data <= {5'd0, res_rec_q, res_st_q};
	end

endmodule

### sv/glyph_cache_atlas_allocator.sv
// ----------------------------------------------------------------------------
// glyph_cache_atlas_allocator: glyph cache with shelf atlas packing
//
//   channel  | direction | fields
//   s_axis   | in        | code_point, in_width, in_height, bearings, advance
//   m_axis   | out       | status, texture_index, atlas_x/y, metrics
//   cfg      | in        | register index, write data
//
// an item's handling time is set by the walk of the bucket and the
// insertion shift, each of which handles one entry at a time in a read
// step and a compare or write step; walk and shift together touch at most
// BUCKET_DEPTH entries
// reset clears fill valid bits and pen state at once; no clearing pass
// a stalled result holds the controller in its handoff state
// ----------------------------------------------------------------------------
module glyph_cache_atlas_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// code_point, in_width, in_height, in_bearing_x, in_bearing_y, in_advance
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, texture_index, atlas_x, atlas_y, out_width, out_height,
	// out_bearing_x, out_bearing_y, out_advance
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	gca_pkg::cmd_t  cmd;
	gca_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	gca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

### sim/tb_glyph_cache_atlas_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_cache_atlas_allocator: self-checking bench of the glyph cache
// drives lookups with random gaps, predicts hits, sorted inserts and shelf
// placement in a scoreboard, and compares every result beat field by field
// ----------------------------------------------------------------------------
module tb_glyph_cache_atlas_allocator;

	typedef struct packed {
		logic [7:0]  adv;
		logic [7:0]  by;
		logic [7:0]  bx;
		logic [7:0]  h;
		logic [7:0]  w;
		logic [20:0] code;
	} lookup_t;

	typedef struct packed {
		logic [2:0]     status;
		gca_pkg::rec_t  rec;
	} placement_t;

	// scoreboard: cache predictor plus queue of expected placements
	class glyph_scoreboard;
		logic [10:0] atlas_w, atlas_h;
		logic [3:0]  pad;
		int unsigned fill [gca_pkg::BUCKETS];
		logic [20:0] keys [gca_pkg::SLOTS];
		gca_pkg::rec_t recs [gca_pkg::SLOTS];
		int unsigned pen_x, pen_y, row_h, tex_count;
		placement_t  pending [$];
		int          errors;

		function new();
			atlas_w = 128; atlas_h = 128; pad = 1;
			foreach (fill[i]) fill[i] = 0;
			pen_x = 0; pen_y = 0; row_h = 0; tex_count = 1; errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [10:0] val);
			case (idx)
				gca_pkg::REG_WIDTH: atlas_w = val;
				gca_pkg::REG_HEIGHT: atlas_h = val;
				gca_pkg::REG_PAD: pad = val[3:0];
				default: ;
			endcase
		endfunction

		function int unsigned clip(int unsigned v, int unsigned top);
			return v > top ? top : v;
		endfunction

		// lookup or insert one glyph
		function void note_lookup(lookup_t it);
			int unsigned bkt, base, n, pos, px, py, rh, tc;
			placement_t  res;
			bkt = it.code % gca_pkg::BUCKETS;
			base = bkt * gca_pkg::BUCKET_DEPTH;
			n = fill[bkt];
			res = '0;
			for (pos = 0; pos < n; pos++) begin
				if (keys[base+pos] > it.code) break;
				if (keys[base+pos] == it.code) begin
					res.status = gca_pkg::ST_HIT;
					res.rec = recs[base+pos];
					pending.push_back(res);
					return;
				end
			end
			if (n >= gca_pkg::BUCKET_DEPTH) begin
				res.status = gca_pkg::ST_FULL;
				pending.push_back(res);
				return;
			end
			px = pen_x; py = pen_y; rh = row_h; tc = tex_count;
			res.status = gca_pkg::ST_INSERT;
			if (px + pad + it.w > atlas_w) begin
				px = pad; py = clip(py + rh, gca_pkg::PEN_MAX); rh = pad;
			end
			if (py + pad + it.h > atlas_h) begin
				if (tc >= gca_pkg::MAX_TEXTURES) begin
					res.status = gca_pkg::ST_EXHAUST;
					pending.push_back(res);
					return;
				end
				px = pad; py = pad; rh = pad; tc++;
				res.status = gca_pkg::ST_NEW_TEX;
			end
			res.rec.tex = 4'(tc - 1);
			res.rec.x = 10'(clip(px, gca_pkg::COORD_MAX));
			res.rec.y = 10'(clip(py, gca_pkg::COORD_MAX));
			res.rec.w = it.w; res.rec.h = it.h;
			res.rec.bx = it.bx; res.rec.by = it.by; res.rec.adv = it.adv;
			for (int k = n; k > pos; k--) begin
				keys[base+k] = keys[base+k-1];
				recs[base+k] = recs[base+k-1];
			end
			keys[base+pos] = it.code;
			recs[base+pos] = res.rec;
			fill[bkt] = n + 1;
			pen_x = clip(px + it.w + pad, gca_pkg::PEN_MAX);
			pen_y = py;
			row_h = clip(rh > it.h + pad ? rh : it.h + pad, gca_pkg::ROW_MAX);
			tex_count = tc;
			pending.push_back(res);
		endfunction

		function void check_result(logic [71:0] beat);
			placement_t got, want;
			// status sits in the lowest bits, the record above it
			got.status = beat[2:0];
			got.rec = beat[66:3];
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) report("status");
			if (got.rec.tex !== want.rec.tex) report("texture_index");
			if (got.rec.x !== want.rec.x) report("atlas_x");
			if (got.rec.y !== want.rec.y) report("atlas_y");
			if (got.rec.w !== want.rec.w) report("out_width");
			if (got.rec.h !== want.rec.h) report("out_height");
			if (got.rec.bx !== want.rec.bx) report("out_bearing_x");
			if (got.rec.by !== want.rec.by) report("out_bearing_y");
			if (got.rec.adv !== want.rec.adv) report("out_advance");
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 50) $display("mismatch at %0t: %s", $time, what);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	glyph_scoreboard sb;
	bit          hold_off = 0;
	bit          no_gaps = 0;
	int          cycles = 0;
	int          inserted_codes [$];
	localparam int CYCLE_LIMIT = 900000;

	glyph_cache_atlas_allocator i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random stalls, long hold-off on request
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 15);
			if (gap != 0 || hold_off) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_result(m_axis_tdata);
		end
	end

	task automatic send_lookup(lookup_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {3'h0, it};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_lookup(it);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic lookup_t rand_glyph(int unsigned max_side);
		lookup_t it;
		it.code = 21'($urandom_range(0, 1114111));
		it.w = 8'($urandom_range(0, max_side));
		it.h = 8'($urandom_range(0, max_side));
		it.bx = 8'($urandom); it.by = 8'($urandom); it.adv = 8'($urandom);
		return it;
	endfunction

	// code likely to repeat or crowd a few buckets
	function automatic lookup_t pick_glyph();
		lookup_t it;
		int unsigned r;
		it = rand_glyph($urandom_range(0, 3) == 0 ? 255 : 40);
		r = $urandom_range(0, 9);
		if (r < 4 && inserted_codes.size() != 0)
			it.code = 21'(inserted_codes[$urandom_range(0, inserted_codes.size() - 1)]);
		else if (r < 7)
			it.code = 21'(($urandom_range(0, 4351) << 8) | $urandom_range(0, 3));
		inserted_codes.push_back(int'(it.code));
		return it;
	endfunction

	initial begin
		lookup_t it;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, hit, sorted insert, wrap, new texture
		it = '{adv: 8'hFF, by: 8'h80, bx: 8'h7F, h: 8'd0, w: 8'd0, code: 21'd0};
		send_lookup(it);
		send_lookup(it);
		it = '{adv: 8'h00, by: 8'h7F, bx: 8'h80, h: 8'd10, w: 8'd20,
			code: 21'h10FFFF};
		send_lookup(it);
		it.code = 21'h1FFFFF; send_lookup(it);
		it.code = 21'h100; it.w = 8'd100; send_lookup(it);
		it.code = 21'h000200; it.w = 8'd255; it.h = 8'd255; send_lookup(it);
		it.code = 21'h000100; send_lookup(it);
		// fill one bucket past its depth, descending codes
		for (int i = 9; i >= 0; i--) begin
			it.code = 21'((i << 8) | 8'h11); it.w = 8'd30; it.h = 8'd30;
			send_lookup(it);
		end
		it.code = 21'h311; send_lookup(it);
		drain();

		// phases over register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(gca_pkg::REG_WIDTH, 11'd1024);
					write_reg(gca_pkg::REG_HEIGHT, 11'd1024);
					write_reg(gca_pkg::REG_PAD, 11'd0); end
				1: begin write_reg(gca_pkg::REG_WIDTH, 11'd128);
					write_reg(gca_pkg::REG_HEIGHT, 11'd128);
					write_reg(gca_pkg::REG_PAD, 11'd15); end
				2: begin write_reg(gca_pkg::REG_WIDTH, 11'd0);
					write_reg(gca_pkg::REG_HEIGHT, 11'd2047);
					write_reg(gca_pkg::REG_PAD, 11'd3); end
				3: begin write_reg(gca_pkg::REG_WIDTH, 11'd2047);
					write_reg(gca_pkg::REG_HEIGHT, 11'd0); end
				default: begin write_reg(gca_pkg::REG_WIDTH, 11'($urandom_range(128, 1024)));
					write_reg(gca_pkg::REG_HEIGHT, 11'($urandom_range(128, 1024)));
					write_reg(gca_pkg::REG_PAD, 11'($urandom_range(0, 15))); end
			endcase
			no_gaps = (ph == 4);
			if (ph == 1) hold_off = 1;
			for (int i = 0; i < 220; i++) begin
				// release the long hold-off while the sender keeps offering
				if (ph == 1 && i == 0) fork
					begin repeat (400) @(posedge clk); hold_off = 0; end
				join_none
				send_lookup(pick_glyph());
			end
			drain();
		end
		no_gaps = 0;

		if (sb.pending.size() == 0 && sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
